// ----- hdl/plt_pkg.sv -----
// ----------------------------------------------------------------------------
// plt_pkg: shared types and codes for the pair link table
// Command and status codes, transaction payload structs, and the
// control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int ID_W          = 64;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;
    localparam int DEPTH_DEFAULT = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RM_PAIR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RM_FIRST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RM_SECOND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HOLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  first_id;
        logic [ID_W-1:0]  second_id;
        logic [ID_W-1:0]  now_time;
    } plt_in_t;

    // Result transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  removed_count;
        logic [ID_W-1:0]     entry_first;
        logic [ID_W-1:0]     entry_second;
        logic [ID_W-1:0]     entry_time;
        logic                entry_valid;
        logic [COUNT_W-1:0]  live_count;
        logic [ID_W-1:0]     modified_time;
        logic                last;
    } plt_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic                load;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                add_direct;
        logic                add_pop;
        logic                add_write_pop;
        logic                scan_start;
        logic                emit_summary;
    } plt_ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hole_hit;
        logic             full;
        logic             free_nonempty;
        logic             table_empty;
        logic             any_live;
        logic             scan_done;
    } plt_sts_t;

endpackage

// ----- hdl/plt_ctrl.sv -----
// ----------------------------------------------------------------------------
// plt_ctrl: command sequencer for the pair link table
// Decodes each accepted command and steps the datapath through add,
// scan and summary phases.
// ----------------------------------------------------------------------------
module plt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  plt_pkg::plt_sts_t  sts,
    output plt_pkg::plt_ctl_t  ctl,
    output logic               busy
);
    import plt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ADD_WR = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd) inside
                    CMD_ADD:
                    begin
                        if (sts.hole_hit)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = ST_HOLE;
                            state_next      = S_FINISH;
                        end
                        else if (sts.full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else if (sts.free_nonempty)
                        begin
                            ctl.add_pop = 1'b1;
                            state_next  = S_ADD_WR;
                        end
                        else
                        begin
                            ctl.add_direct = 1'b1;
                            state_next     = S_FINISH;
                        end
                    end
                    CMD_RM_PAIR, CMD_RM_FIRST, CMD_RM_SECOND:
                    begin
                        if (sts.hole_hit)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = ST_HOLE;
                            state_next      = S_FINISH;
                        end
                        else if (sts.table_empty)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (sts.any_live)
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ADD_WR:
            begin
                ctl.add_write_pop = 1'b1;
                state_next        = S_FINISH;
            end
            S_SCAN:
            begin
                // A dump delivers its own results during the scan.
                if (sts.scan_done)
                begin
                    state_next = (sts.cmd == CMD_DUMP) ? S_IDLE : S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctl.emit_summary = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- hdl/plt_dpath.sv -----
// ----------------------------------------------------------------------------
// plt_dpath: storage and scan datapath for the pair link table
// Holds the entry memories, the free slot stack, live bits, counters,
// the slot scan pipeline and the result register.
// ----------------------------------------------------------------------------
module plt_dpath #(
    parameter int TABLE_DEPTH = plt_pkg::DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  plt_pkg::plt_in_t       item,
    input  logic                   cfg_we,
    input  logic [plt_pkg::ID_W-1:0] cfg_wdata,
    input  plt_pkg::plt_ctl_t      ctl,
    output plt_pkg::plt_sts_t      sts,
    output plt_pkg::plt_out_t      result,
    output logic                   result_valid
);
    import plt_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);

    // Entry memories and the free slot stack.
    logic [ID_W-1:0]   first_mem  [TABLE_DEPTH];
    logic [ID_W-1:0]   second_mem [TABLE_DEPTH];
    logic [ID_W-1:0]   time_mem   [TABLE_DEPTH];
    logic [SLOT_W-1:0] stack_mem  [TABLE_DEPTH];

    plt_in_t             op_reg;
    logic [ID_W-1:0]     hole_reg;
    logic [COUNT_W-1:0]  used_reg,   used_next;
    logic [COUNT_W-1:0]  free_reg,   free_next;
    logic [ID_W-1:0]     mod_reg,    mod_next;
    logic [TABLE_DEPTH-1:0] live_reg, live_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  cnt_reg,    cnt_next;
    logic [COUNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic                rd_active_reg, rd_active_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic [ID_W-1:0]     first_rd_reg;
    logic [ID_W-1:0]     second_rd_reg;
    logic [ID_W-1:0]     time_rd_reg;
    logic [SLOT_W-1:0]   stack_rd_reg;
    plt_out_t            result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    logic                key_match;
    logic                hit;
    logic                is_dump;
    logic                scan_last;
    logic                scan_done;
    logic                remove_hit;
    logic                dump_hit;
    logic                hole_hit;
    logic [TABLE_DEPTH-1:0] live_above;
    logic [COUNT_W-1:0]  pop_cnt;
    logic                entry_we;
    logic [SLOT_W-1:0]   entry_waddr;

    // Operand capture and the reserved id register.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_reg <= '0;
        end
        else if (cfg_we)
        begin
            hole_reg <= cfg_wdata;
        end
    end

    // Reserved id check on the captured operands.
    always_comb
    begin
        unique case (op_reg.command) inside
            CMD_ADD, CMD_RM_PAIR:
                hole_hit = (op_reg.first_id == hole_reg) || (op_reg.second_id == hole_reg);
            CMD_RM_FIRST:  hole_hit = (op_reg.first_id == hole_reg);
            CMD_RM_SECOND: hole_hit = (op_reg.second_id == hole_reg);
            default:       hole_hit = 1'b0;
        endcase
    end

    // Compare stage: the slot read last cycle against the operands.
    always_comb
    begin
        unique case (op_reg.command)
            CMD_RM_PAIR:
                key_match = (first_rd_reg == op_reg.first_id) &&
                            (second_rd_reg == op_reg.second_id);
            CMD_RM_FIRST:  key_match = (first_rd_reg == op_reg.first_id);
            CMD_RM_SECOND: key_match = (second_rd_reg == op_reg.second_id);
            default:       key_match = 1'b1;
        endcase
    end

    assign is_dump    = (op_reg.command == CMD_DUMP);
    assign hit        = cmp_valid_reg && live_reg[cmp_idx_reg] && key_match;
    assign scan_last  = (COUNT_W'(cmp_idx_reg) == (used_reg - COUNT_W'(1)));
    assign scan_done  = cmp_valid_reg &&
                        (scan_last || (hit && (op_reg.command == CMD_RM_PAIR)));
    assign remove_hit = hit && !is_dump;
    assign dump_hit   = hit && is_dump;
    assign live_above = (live_reg >> cmp_idx_reg) >> 1;
    assign pop_cnt    = free_reg - COUNT_W'(1);

    // Entry write port: appended slot or the slot popped from the stack.
    assign entry_we    = ctl.add_direct || ctl.add_write_pop;
    assign entry_waddr = ctl.add_direct ? used_reg[SLOT_W-1:0] : stack_rd_reg;

    // Status to the controller.
    always_comb
    begin
        sts.cmd           = op_reg.command;
        sts.hole_hit      = hole_hit;
        sts.full          = (free_reg == '0) && (used_reg == COUNT_W'(TABLE_DEPTH));
        sts.free_nonempty = (free_reg != '0);
        sts.table_empty   = (used_reg == '0);
        sts.any_live      = |live_reg;
        sts.scan_done     = scan_done;
    end

    // Next state of the table bookkeeping, scan pipeline and result.
    always_comb
    begin
        used_next         = used_reg;
        free_next         = free_reg;
        mod_next          = mod_reg;
        live_next         = live_reg;
        status_next       = status_reg;
        cnt_next          = cnt_reg;
        rd_idx_next       = rd_idx_reg;
        rd_active_next    = rd_active_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        if (ctl.load)
        begin
            status_next = ST_OK;
            cnt_next    = '0;
        end
        if (ctl.set_status)
        begin
            status_next = ctl.status_code;
        end

        // Add into a fresh slot or into the most recently freed one.
        if (ctl.add_direct)
        begin
            used_next                       = used_reg + COUNT_W'(1);
            live_next[used_reg[SLOT_W-1:0]] = 1'b1;
            mod_next                        = op_reg.now_time;
        end
        if (ctl.add_pop)
        begin
            free_next = pop_cnt;
        end
        if (ctl.add_write_pop)
        begin
            live_next[stack_rd_reg] = 1'b1;
            mod_next                = op_reg.now_time;
        end

        // Slot scan read address.
        if (ctl.scan_start)
        begin
            rd_idx_next    = '0;
            rd_active_next = 1'b1;
        end
        else if (rd_active_reg)
        begin
            rd_idx_next = rd_idx_reg + COUNT_W'(1);
            if (scan_done || ((rd_idx_reg + COUNT_W'(1)) == used_reg))
            begin
                rd_active_next = 1'b0;
            end
        end
        cmp_valid_next = rd_active_reg && !scan_done;
        cmp_idx_next   = rd_idx_reg[SLOT_W-1:0];

        // A matching live slot is freed and pushed on the stack.
        if (remove_hit)
        begin
            live_next[cmp_idx_reg] = 1'b0;
            free_next              = free_reg + COUNT_W'(1);
            cnt_next               = cnt_reg + COUNT_W'(1);
            mod_next               = op_reg.now_time;
        end

        // Result register.
        if (ctl.emit_summary)
        begin
            result_next.status        = status_reg;
            result_next.removed_count = cnt_reg;
            result_next.entry_first   = '0;
            result_next.entry_second  = '0;
            result_next.entry_time    = '0;
            result_next.entry_valid   = 1'b0;
            result_next.live_count    = used_reg - free_reg;
            result_next.modified_time = mod_reg;
            result_next.last          = 1'b1;
            result_valid_next         = 1'b1;
        end
        else if (dump_hit)
        begin
            result_next.status        = ST_OK;
            result_next.removed_count = '0;
            result_next.entry_first   = first_rd_reg;
            result_next.entry_second  = second_rd_reg;
            result_next.entry_time    = time_rd_reg;
            result_next.entry_valid   = 1'b1;
            result_next.live_count    = used_reg - free_reg;
            result_next.modified_time = mod_reg;
            result_next.last          = ~|live_above;
            result_valid_next         = 1'b1;
        end
    end

    // Control and bookkeeping registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            free_reg         <= '0;
            mod_reg          <= '0;
            live_reg         <= '0;
            status_reg       <= ST_OK;
            cnt_reg          <= '0;
            rd_idx_reg       <= '0;
            rd_active_reg    <= 1'b0;
            cmp_valid_reg    <= 1'b0;
            cmp_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg         <= used_next;
            free_reg         <= free_next;
            mod_reg          <= mod_next;
            live_reg         <= live_next;
            status_reg       <= status_next;
            cnt_reg          <= cnt_next;
            rd_idx_reg       <= rd_idx_next;
            rd_active_reg    <= rd_active_next;
            cmp_valid_reg    <= cmp_valid_next;
            cmp_idx_reg      <= cmp_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Entry memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            first_mem[entry_waddr]  <= op_reg.first_id;
            second_mem[entry_waddr] <= op_reg.second_id;
            time_mem[entry_waddr]   <= op_reg.now_time;
        end
        first_rd_reg  <= first_mem[rd_idx_reg[SLOT_W-1:0]];
        second_rd_reg <= second_mem[rd_idx_reg[SLOT_W-1:0]];
        time_rd_reg   <= time_mem[rd_idx_reg[SLOT_W-1:0]];
    end

    // Free slot stack: push on removal, registered read of the top.
    always_ff @(posedge clk)
    begin
        if (remove_hit)
        begin
            stack_mem[free_reg[SLOT_W-1:0]] <= cmp_idx_reg;
        end
        stack_rd_reg <= stack_mem[pop_cnt[SLOT_W-1:0]];
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ----- hdl/pair_link_table_with_free_stack.sv -----
// ----------------------------------------------------------------------------
// pair_link_table_with_free_stack: table of id pair links with slot reuse
// Adds, removes and dumps link entries; freed slots go on a LIFO stack
// and are reused by later adds before new slots are appended.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ----------------------------
//  command   in         start high, busy low      item (plt_in_t)
//  result    out        result_valid, one cycle   result (plt_out_t)
//  config    in         cfg_we                    cfg_wdata (reserved hole id)
//
//  An add that reuses a freed slot passes through an extra state for the
//  registered stack read; rejected and spare commands go straight to the
//  summary. Removals and dumps walk the slots below the fill mark one per
//  cycle; remove pair stops at the first match. Each result is registered
//  before it appears. Reset clears the counters, live bits and the hole id;
//  the memories are left as they are. The receiver cannot stall results.
//
module pair_link_table_with_free_stack #(
    parameter int TABLE_DEPTH = plt_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  plt_pkg::plt_in_t         item,
    output plt_pkg::plt_out_t        result,
    output logic                     result_valid,
    input  logic                     cfg_we,
    input  logic [plt_pkg::ID_W-1:0] cfg_wdata
);
    import plt_pkg::*;

    plt_ctl_t ctl;
    plt_sts_t sts;

    // Command sequencer.
    plt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Storage, scan pipeline and result register.
    plt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ctl          (ctl),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

    // An accepted transaction always occupies the block the next cycle.
    a_busy_after_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy
    ) else $error("busy not raised after an accepted transaction");

    // The final result of a command is never followed by another at once.
    a_gap_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid
    ) else $error("result directly after a final result");

    // The live count never exceeds the table size.
    a_live_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> result.live_count <= COUNT_W'(TABLE_DEPTH)
    ) else $error("live count beyond table depth");

    // A scan never runs while no command is in progress.
    a_scan_in_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        sts.scan_done |-> busy
    ) else $error("scan activity outside a command");

endmodule
